@@ design/mfd_pkg.sv @@
// ----------------------------------------------------------------------------
// mfd_pkg
// Shared types and constants for the monochrome frame store draw unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mfd_pkg;

  localparam int PANEL_WIDTH_DEF  = 128;
  localparam int PANEL_HEIGHT_DEF = 64;

  // Internal coordinate width: exact for 16-bit operands plus panel offsets
  localparam int CW = 20;

  localparam logic [2:0] OP_PIXEL = 3'd0;
  localparam logic [2:0] OP_HLINE = 3'd1;
  localparam logic [2:0] OP_VLINE = 3'd2;
  localparam logic [2:0] OP_CLEAR = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;

  localparam logic [1:0] COL_BLACK  = 2'd0;
  localparam logic [1:0] COL_WHITE  = 2'd1;
  localparam logic [1:0] COL_INVERT = 2'd2;
  localparam logic [1:0] COL_NONE   = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_READ,
    ST_RDOUT,
    ST_FIX,
    ST_END1,
    ST_END2,
    ST_CLIP,
    ST_BASE,
    ST_ADDR,
    ST_RUN,
    ST_LAST
  } state_e;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] length;
    logic [1:0]         color;
    logic [9:0]         byte_index;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       drew;
  } result_t;

endpackage

`default_nettype wire

@@ design/mfd_ram.sv @@
// ----------------------------------------------------------------------------
// mfd_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module mfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ design/mono_framebuffer_draw_unit.sv @@
// ----------------------------------------------------------------------------
// mono_framebuffer_draw_unit
// Page-organised monochrome frame store with pixel and line drawing.
// Pixel/line: FIX, END1, END2, CLIP, BASE, ADDR, RUN (one byte per cycle, read
// and write overlapped on the two RAM ports), LAST; clipped to nothing: ends
// after CLIP. Read: READ, RDOUT. Clear: zeroes PANEL_WIDTH * PANEL_HEIGHT / 8
// bytes. Colour 3 or unused op: no busy. Result strobe in the cycle after the
// last state; busy low while it shows. Reset: rotation 0, then a clear sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module mono_framebuffer_draw_unit #(
  parameter int PANEL_WIDTH  = mfd_pkg::PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = mfd_pkg::PANEL_HEIGHT_DEF
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  output logic                 busy,
  input  wire mfd_pkg::item_t  item_i,
  input  wire logic            cfg_we_i,
  input  wire logic [1:0]      cfg_wdata_i,
  output logic                 done_o,
  output mfd_pkg::result_t     result_o
);

  import mfd_pkg::*;

  localparam int DEPTH   = PANEL_WIDTH * (PANEL_HEIGHT / 8);
  localparam int AW      = $clog2(DEPTH);
  localparam int DIM_MAX = (PANEL_WIDTH > PANEL_HEIGHT) ? PANEL_WIDTH : PANEL_HEIGHT;
  localparam int LW      = $clog2(DIM_MAX + 1);
  localparam int PAGES   = PANEL_HEIGHT / 8;
  localparam int PGW     = (PAGES > 1) ? $clog2(PAGES) : 1;

  localparam logic signed [CW-1:0] W_S   = CW'(PANEL_WIDTH);
  localparam logic signed [CW-1:0] H_S   = CW'(PANEL_HEIGHT);
  localparam logic signed [CW-1:0] W1_S  = CW'(PANEL_WIDTH - 1);
  localparam logic signed [CW-1:0] H1_S  = CW'(PANEL_HEIGHT - 1);
  localparam logic signed [CW-1:0] ONE_S = CW'(1);
  localparam logic signed [CW-1:0] ZERO_S = '0;

  state_e state_q, state_d;

  logic [1:0]         rot_q;
  logic [2:0]         op_q;
  logic signed [15:0] x_q, y_q, len_q;
  logic [1:0]         color_q;
  logic [9:0]         idx_q;

  logic signed [CW-1:0] c_q, c_d, s_q, s_d, e_q, e_d;
  logic [LW-1:0]        sc_q, sc_d, ec_q, ec_d, cur_q, cur_d, last_q, last_d;
  logic [AW-1:0]        base_q, base_d, addr_q, addr_d, clr_addr_q, clr_addr_d;
  logic [AW-1:0]        wa_q;
  logic [7:0]           wm_q;
  logic                 wv_q, wv_d;
  logic                 clr_report_q, clr_report_d;
  logic                 done_q, done_d;
  result_t              res_q, res_d;

  logic accept;
  logic load_item;

  // Shared adder
  logic signed [CW-1:0] alu_a, alu_b;
  logic                 alu_sub;
  logic [CW-1:0]        alu_y;

  // RAM ports
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  // Geometry decode
  logic                 hv, vert, run_rev, fix_rev, is_pixel;
  logic signed [CW-1:0] x_ext, y_ext, len_ext, len_eff;
  logic signed [CW-1:0] fix_src, run_src, fix_k1, run_k, fix_lim, run_lim;
  logic signed [CW-1:0] s_cl, e_cl;
  logic signed [CW-1:0] lw_s, lh_s;
  logic                 pix_ok, fix_ok, empty;
  logic [PGW-1:0]       page;
  logic [2:0]           lo;
  logic [3:0]           hi;
  logic [7:0]           run_mask;
  logic [7:0]           wdata_mod;
  logic                 rd_ok;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  assign x_ext   = CW'(x_q);
  assign y_ext   = CW'(y_q);
  assign len_ext = CW'(len_q);

  assign is_pixel = (op_q == OP_PIXEL);
  assign hv       = (op_q == OP_VLINE);
  assign vert     = hv ^ rot_q[0];
  assign run_rev  = hv ? (rot_q[0] ^ rot_q[1]) : rot_q[1];
  assign fix_rev  = hv ? rot_q[1] : (rot_q[0] ^ rot_q[1]);
  assign fix_src  = hv ? x_ext : y_ext;
  assign run_src  = hv ? y_ext : x_ext;
  assign len_eff  = is_pixel ? ONE_S : len_ext;
  assign fix_k1   = vert ? W1_S : H1_S;
  assign run_k    = vert ? H_S : W_S;
  assign fix_lim  = vert ? W_S : H_S;
  assign run_lim  = vert ? H_S : W_S;

  assign lw_s   = rot_q[0] ? H_S : W_S;
  assign lh_s   = rot_q[0] ? W_S : H_S;
  assign pix_ok = (x_ext >= ZERO_S) && (x_ext < lw_s) && (y_ext >= ZERO_S) && (y_ext < lh_s);

  assign s_cl   = (s_q < ZERO_S) ? ZERO_S : s_q;
  assign e_cl   = (e_q > run_lim) ? run_lim : e_q;
  assign fix_ok = (c_q >= ZERO_S) && (c_q < fix_lim);
  assign empty  = !fix_ok || (e_cl <= s_cl) || (is_pixel && !pix_ok);

  assign page = vert ? PGW'(sc_q >> 3) : PGW'(c_q[CW-1:3]);

  // Byte mask for the current column or page
  assign lo = (cur_q == (sc_q >> 3)) ? sc_q[2:0] : 3'd0;
  assign hi = (cur_q < (ec_q >> 3)) ? 4'd8 : {1'b0, ec_q[2:0]};
  assign run_mask = vert ? ((8'hFF << lo) & (8'hFF >> (4'd8 - hi)))
                         : (8'h01 << c_q[2:0]);

  assign rd_ok = (int'(idx_q) < DEPTH);

  assign alu_y = alu_a + (alu_sub ? ~alu_b : alu_b) + {{(CW-1){1'b0}}, alu_sub};

  always_comb begin
    case (color_q)
      COL_BLACK: wdata_mod = ram_rdata & ~wm_q;
      COL_WHITE: wdata_mod = ram_rdata | wm_q;
      default:   wdata_mod = ram_rdata ^ wm_q;
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (item_i.operation) inside
            OP_PIXEL, OP_HLINE, OP_VLINE: begin
              state_d = (item_i.color == COL_NONE) ? ST_IDLE : ST_FIX;
            end
            OP_CLEAR: state_d = ST_CLEAR;
            OP_READ:  state_d = ST_READ;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_CLEAR: begin
        if (clr_addr_q == AW'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_READ:  state_d = ST_RDOUT;
      ST_RDOUT: state_d = ST_IDLE;
      ST_FIX:   state_d = ST_END1;
      ST_END1:  state_d = ST_END2;
      ST_END2:  state_d = ST_CLIP;
      ST_CLIP:  state_d = empty ? ST_IDLE : ST_BASE;
      ST_BASE:  state_d = ST_ADDR;
      ST_ADDR:  state_d = ST_RUN;
      ST_RUN: begin
        if (cur_q == last_q) begin
          state_d = ST_LAST;
        end
      end
      ST_LAST:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Outputs and datapath
  always_comb begin
    load_item    = 1'b0;
    alu_a        = ZERO_S;
    alu_b        = ZERO_S;
    alu_sub      = 1'b0;
    c_d          = c_q;
    s_d          = s_q;
    e_d          = e_q;
    sc_d         = sc_q;
    ec_d         = ec_q;
    cur_d        = cur_q;
    last_d       = last_q;
    base_d       = base_q;
    addr_d       = addr_q;
    clr_addr_d   = clr_addr_q;
    clr_report_d = clr_report_q;
    wv_d         = 1'b0;
    ram_re       = 1'b0;
    ram_raddr    = addr_q;
    ram_we       = wv_q;
    ram_waddr    = wa_q;
    ram_wdata    = wdata_mod;
    done_d       = 1'b0;
    res_d        = '0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          load_item = 1'b1;
          case (item_i.operation) inside
            OP_PIXEL, OP_HLINE, OP_VLINE: begin
              done_d = (item_i.color == COL_NONE);
            end
            OP_CLEAR: begin
              clr_addr_d   = '0;
              clr_report_d = 1'b1;
            end
            OP_READ: ;
            default: done_d = 1'b1;
          endcase
        end
      end
      ST_CLEAR: begin
        ram_we     = 1'b1;
        ram_waddr  = clr_addr_q;
        ram_wdata  = '0;
        clr_addr_d = clr_addr_q + AW'(1);
        if (clr_addr_q == AW'(DEPTH - 1)) begin
          done_d       = clr_report_q;
          res_d.drew   = 1'b1;
          clr_report_d = 1'b0;
        end
      end
      ST_READ: begin
        ram_re    = 1'b1;
        ram_raddr = AW'(idx_q);
      end
      ST_RDOUT: begin
        done_d          = 1'b1;
        res_d.read_data = rd_ok ? ram_rdata : 8'h00;
      end
      ST_FIX: begin
        if (fix_rev) begin
          alu_a   = fix_k1;
          alu_b   = fix_src;
          alu_sub = 1'b1;
        end else begin
          alu_a = fix_src;
        end
        c_d = $signed(alu_y);
      end
      ST_END1: begin
        if (run_rev) begin
          alu_a   = run_k;
          alu_b   = run_src;
          alu_sub = 1'b1;
          e_d     = $signed(alu_y);
        end else begin
          alu_a = run_src;
          s_d   = $signed(alu_y);
        end
      end
      ST_END2: begin
        alu_b = len_eff;
        if (run_rev) begin
          alu_a   = e_q;
          alu_sub = 1'b1;
          s_d     = $signed(alu_y);
        end else begin
          alu_a = s_q;
          e_d   = $signed(alu_y);
        end
      end
      ST_CLIP: begin
        sc_d = s_cl[LW-1:0];
        ec_d = e_cl[LW-1:0];
        if (empty) begin
          done_d = 1'b1;
        end
      end
      ST_BASE: begin
        base_d = AW'(page * PANEL_WIDTH);
        if (vert) begin
          cur_d  = sc_q >> 3;
          last_d = (ec_q - LW'(1)) >> 3;
        end else begin
          cur_d  = sc_q;
          last_d = ec_q - LW'(1);
        end
      end
      ST_ADDR: begin
        alu_a  = {{(CW-AW){1'b0}}, base_q};
        alu_b  = vert ? {{(CW-LW){1'b0}}, c_q[LW-1:0]} : {{(CW-LW){1'b0}}, sc_q};
        addr_d = alu_y[AW-1:0];
      end
      ST_RUN: begin
        ram_re = 1'b1;
        wv_d   = 1'b1;
        alu_a  = {{(CW-AW){1'b0}}, addr_q};
        alu_b  = vert ? W_S : ONE_S;
        addr_d = alu_y[AW-1:0];
        cur_d  = cur_q + LW'(1);
      end
      ST_LAST: begin
        done_d     = 1'b1;
        res_d.drew = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      rot_q        <= 2'd0;
      clr_addr_q   <= '0;
      clr_report_q <= 1'b0;
      wv_q         <= 1'b0;
      done_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_addr_q   <= clr_addr_d;
      clr_report_q <= clr_report_d;
      wv_q         <= wv_d;
      done_q       <= done_d;
      if (cfg_we_i) begin
        rot_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_item) begin
      op_q    <= item_i.operation;
      x_q     <= item_i.pos_x;
      y_q     <= item_i.pos_y;
      len_q   <= item_i.length;
      color_q <= item_i.color;
      idx_q   <= item_i.byte_index;
    end
    c_q    <= c_d;
    s_q    <= s_d;
    e_q    <= e_d;
    sc_q   <= sc_d;
    ec_q   <= ec_d;
    cur_q  <= cur_d;
    last_q <= last_d;
    base_q <= base_d;
    addr_q <= addr_d;
    wa_q   <= addr_q;
    wm_q   <= run_mask;
    res_q  <= res_d;
  end

  mfd_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign done_o   = done_q;
  assign result_o = res_q;

  // Assertions
  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  a_wr_in_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wv_q |-> (state_q == ST_RUN || state_q == ST_LAST))
    else $error("byte write outside a line run");

  a_accept_progress : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (done_o || busy))
    else $error("accepted transaction neither answered nor in progress");

  a_clear_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> (int'(clr_addr_q) < DEPTH))
    else $error("clear sweep address beyond store");

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the monochrome frame store draw unit. A directed
// set of draw, clear and read transactions is followed by random phases,
// each under its own rotation. Every accepted transaction is run through a
// shadow frame store and the predicted result is compared with the strobed
// result in order.
// ----------------------------------------------------------------------------

module testbench;
  import mfd_pkg::*;

  localparam int PANEL_W     = PANEL_WIDTH_DEF;
  localparam int PANEL_H     = PANEL_HEIGHT_DEF;
  localparam int PAGES       = PANEL_H / 8;
  localparam int STORE_DEPTH = PANEL_W * PAGES;
  localparam int NUM_PHASES  = 8;
  localparam int PHASE_CMDS  = 178;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int MAX_REPORTS = 10;

  localparam logic [2:0] OP_SPARE_FIRST = OP_READ + 3'd1;
  localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

  typedef enum logic [1:0] {ROT_NONE, ROT_90, ROT_180, ROT_270} rot_e;

  localparam rot_e PHASE_ROT [NUM_PHASES] = '{ROT_270, ROT_90, ROT_NONE, ROT_180,
                                              ROT_270, ROT_180, ROT_90, ROT_NONE};

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       start       = 1'b0;
  logic       busy;
  item_t      item_i      = '0;
  logic       cfg_we_i    = 1'b0;
  logic [1:0] cfg_wdata_i = '0;
  logic       done_o;
  result_t    result_o;

  item_t      draw_cmds [$];
  result_t    pending_results [$];
  logic [7:0] shadow_store [STORE_DEPTH];
  rot_e       shadow_rot = ROT_NONE;
  int         sender_idle_pct = 29;
  int         mismatch_count = 0;
  int         cycle_count = 0;

  mono_framebuffer_draw_unit #(
    .PANEL_WIDTH (PANEL_W),
    .PANEL_HEIGHT(PANEL_H)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .item_i     (item_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .done_o     (done_o),
    .result_o   (result_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---- shadow frame store ---------------------------------------------------

  function automatic bit touch_byte(int col, int page, logic [1:0] colour,
                                    logic [7:0] mask);
    int idx;
    if (col < 0 || col >= PANEL_W || page < 0 || page >= PAGES) return 1'b0;
    idx = col + page * PANEL_W;
    case (colour)
      COL_BLACK: shadow_store[idx] = shadow_store[idx] & ~mask;
      COL_WHITE: shadow_store[idx] = shadow_store[idx] | mask;
      default:   shadow_store[idx] = shadow_store[idx] ^ mask;
    endcase
    return 1'b1;
  endfunction

  function automatic bit run_horizontal(int x, int y, int w, logic [1:0] colour);
    bit any;
    int i;
    any = 1'b0;
    if (y < 0 || y >= PANEL_H) return 1'b0;
    if (x < 0) begin
      w = w + x;
      x = 0;
    end
    if (x + w > PANEL_W) w = PANEL_W - x;
    if (w <= 0) return 1'b0;
    for (i = x; i < x + w; i++) begin
      any = any | touch_byte(i, y / 8, colour, 8'(1 << (y & 7)));
    end
    return any;
  endfunction

  function automatic bit run_vertical(int x, int y, int h, logic [1:0] colour);
    bit         any;
    int         stop, page, lo, hi;
    logic [7:0] mask;
    any = 1'b0;
    if (x < 0 || x >= PANEL_W) return 1'b0;
    if (y < 0) begin
      h = h + y;
      y = 0;
    end
    if (y + h > PANEL_H) h = PANEL_H - y;
    if (h <= 0) return 1'b0;
    stop = y + h;
    for (page = y / 8; page * 8 < stop; page++) begin
      lo = (y - page * 8 < 0) ? 0 : y - page * 8;
      hi = (stop - page * 8 > 8) ? 8 : stop - page * 8;
      mask = (8'hFF << lo) & (8'hFF >> (8 - hi));
      any = any | touch_byte(x, page, colour, mask);
    end
    return any;
  endfunction

  function automatic bit plot_pixel(int x, int y, logic [1:0] colour);
    int lw, lh, px, py;
    lw = shadow_rot[0] ? PANEL_H : PANEL_W;
    lh = shadow_rot[0] ? PANEL_W : PANEL_H;
    if (x < 0 || x >= lw || y < 0 || y >= lh) return 1'b0;
    case (shadow_rot)
      ROT_90: begin
        px = PANEL_W - y - 1;
        py = x;
      end
      ROT_180: begin
        px = PANEL_W - x - 1;
        py = PANEL_H - y - 1;
      end
      ROT_270: begin
        px = y;
        py = PANEL_H - x - 1;
      end
      default: begin
        px = x;
        py = y;
      end
    endcase
    return touch_byte(px, py / 8, colour, 8'(1 << (py & 7)));
  endfunction

  function automatic result_t draw_outcome(item_t cmd);
    result_t    res;
    int         x, y, len;
    logic [1:0] colour;
    res = '0;
    x = $signed(cmd.pos_x);
    y = $signed(cmd.pos_y);
    len = $signed(cmd.length);
    colour = cmd.color;
    if (cmd.operation <= OP_VLINE && colour == COL_NONE) return res;
    case (cmd.operation)
      OP_PIXEL: res.drew = plot_pixel(x, y, colour);
      OP_HLINE: begin
        case (shadow_rot)
          ROT_90:  res.drew = run_vertical(PANEL_W - y - 1, x, len, colour);
          ROT_180: res.drew = run_horizontal(PANEL_W - x - 1 - (len - 1), PANEL_H - y - 1,
                                             len, colour);
          ROT_270: res.drew = run_vertical(y, PANEL_H - x - 1 - (len - 1), len, colour);
          default: res.drew = run_horizontal(x, y, len, colour);
        endcase
      end
      OP_VLINE: begin
        case (shadow_rot)
          ROT_90:  res.drew = run_horizontal(PANEL_W - y - 1 - (len - 1), x, len, colour);
          ROT_180: res.drew = run_vertical(PANEL_W - x - 1, PANEL_H - y - 1 - (len - 1),
                                           len, colour);
          ROT_270: res.drew = run_horizontal(y, PANEL_H - x - 1, len, colour);
          default: res.drew = run_vertical(x, y, len, colour);
        endcase
      end
      OP_CLEAR: begin
        foreach (shadow_store[i]) shadow_store[i] = '0;
        res.drew = 1'b1;
      end
      OP_READ: begin
        if (cmd.byte_index < STORE_DEPTH) res.read_data = shadow_store[cmd.byte_index];
      end
      default: ;
    endcase
    return res;
  endfunction

  // ---- stimulus generation ----------------------------------------------------

  function automatic logic [15:0] pick_coord();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 16'($urandom);
    if (sel == 1) begin
      case ($urandom_range(0, 3))
        0:       return 16'h8000;
        1:       return 16'h7FFF;
        2:       return 16'hFFFF;
        default: return 16'h0000;
      endcase
    end
    return 16'(int'($urandom_range(0, 180)) - 20);
  endfunction

  function automatic logic [15:0] pick_length();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 16'($urandom);
    if (sel == 1) begin
      case ($urandom_range(0, 4))
        0:       return 16'h8000;
        1:       return 16'h7FFF;
        2:       return 16'hFFFF;
        3:       return 16'h0001;
        default: return 16'h0000;
      endcase
    end
    return 16'(int'($urandom_range(0, 150)) - 8);
  endfunction

  function automatic item_t random_draw_cmd();
    item_t cmd;
    int    w;
    w = $urandom_range(0, 99);
    if (w < 30)      cmd.operation = OP_PIXEL;
    else if (w < 55) cmd.operation = OP_HLINE;
    else if (w < 80) cmd.operation = OP_VLINE;
    else if (w < 96) cmd.operation = OP_READ;
    else if (w < 97) cmd.operation = OP_CLEAR;
    else cmd.operation = 3'($urandom_range(int'(OP_SPARE_FIRST), int'(OP_SPARE_LAST)));
    cmd.pos_x = pick_coord();
    cmd.pos_y = pick_coord();
    cmd.length = pick_length();
    if ($urandom_range(0, 15) == 0) cmd.color = COL_NONE;
    else cmd.color = 2'($urandom_range(int'(COL_BLACK), int'(COL_INVERT)));
    cmd.byte_index = 10'($urandom);
    return cmd;
  endfunction

  task automatic queue_cmd(logic [2:0] op, int x, int y, int len, logic [1:0] colour,
                           int idx);
    item_t cmd;
    cmd.operation = op;
    cmd.pos_x = 16'(x);
    cmd.pos_y = 16'(y);
    cmd.length = 16'(len);
    cmd.color = colour;
    cmd.byte_index = 10'(idx);
    draw_cmds.push_back(cmd);
  endtask

  task automatic drain();
    do @(negedge clk_i);
    while (draw_cmds.size() != 0 || start || pending_results.size() != 0);
  endtask

  task automatic log_fault(string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("%s", msg);
  endtask

  // ---- driver: one transaction per start/busy handshake -----------------------

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) pending_results.push_back(draw_outcome(item_i));
      if (!start || !busy) begin
        if (draw_cmds.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          item_i <= draw_cmds.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---- monitor ------------------------------------------------------------------

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        log_fault($sformatf("unexpected result: read_data %02h drew %0b",
                            result_o.read_data, result_o.drew));
      end else begin
        want = pending_results.pop_front();
        if (result_o.read_data !== want.read_data || result_o.drew !== want.drew)
          log_fault($sformatf("mismatch: read_data exp %02h got %02h, drew exp %0b got %0b",
                              want.read_data, result_o.read_data, want.drew,
                              result_o.drew));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---- sequence -------------------------------------------------------------------

  initial begin
    int p, k;
    foreach (shadow_store[i]) shadow_store[i] = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed set under the reset rotation
    @(negedge clk_i);
    queue_cmd(OP_PIXEL, 0, 0, 0, COL_WHITE, 0);
    queue_cmd(OP_PIXEL, PANEL_W - 1, PANEL_H - 1, 0, COL_WHITE, 0);
    queue_cmd(OP_PIXEL, -1, 0, 0, COL_WHITE, 0);
    queue_cmd(OP_PIXEL, PANEL_W, 0, 0, COL_WHITE, 0);
    queue_cmd(OP_PIXEL, -32768, 32767, 0, COL_INVERT, 0);
    queue_cmd(OP_PIXEL, 5, 5, 0, COL_NONE, 0);
    queue_cmd(OP_HLINE, -5, 10, 20, COL_WHITE, 0);
    queue_cmd(OP_HLINE, 0, PANEL_H - 1, PANEL_W, COL_INVERT, 0);
    queue_cmd(OP_HLINE, 100, 5, 32767, COL_BLACK, 0);
    queue_cmd(OP_HLINE, 10, 20, 0, COL_WHITE, 0);
    queue_cmd(OP_HLINE, 10, 20, -5, COL_WHITE, 0);
    queue_cmd(OP_VLINE, 3, 5, 12, COL_WHITE, 0);
    queue_cmd(OP_VLINE, PANEL_W - 1, -10, 32767, COL_WHITE, 0);
    queue_cmd(OP_VLINE, 10, 0, PANEL_H, COL_INVERT, 0);
    queue_cmd(OP_VLINE, 10, 60, -32768, COL_WHITE, 0);
    queue_cmd(OP_READ, 0, 0, 0, COL_BLACK, 3);
    queue_cmd(OP_READ, 0, 0, 0, COL_BLACK, PANEL_W + 3);
    queue_cmd(OP_READ, 0, 0, 0, COL_BLACK, 2 * PANEL_W + 3);
    queue_cmd(OP_READ, 0, 0, 0, COL_BLACK, STORE_DEPTH - 1);
    queue_cmd(OP_PIXEL, 0, 0, 0, COL_WHITE, 0);
    for (k = 0; k < 3; k++)
      queue_cmd(3'(OP_SPARE_FIRST + k), 1, 1, 1, COL_WHITE, 10'h3FF);
    queue_cmd(OP_CLEAR, 0, 0, 0, COL_WHITE, 0);
    queue_cmd(OP_READ, 0, 0, 0, COL_BLACK, STORE_DEPTH - 1);
    drain();

    for (p = 0; p < NUM_PHASES; p++) begin
      @(posedge clk_i);
      cfg_we_i <= 1'b1;
      cfg_wdata_i <= PHASE_ROT[p];
      @(posedge clk_i);
      cfg_we_i <= 1'b0;
      shadow_rot = PHASE_ROT[p];
      @(negedge clk_i);
      sender_idle_pct = (p < 3) ? 29 : (p < 6) ? 66 : 0;
      for (k = 0; k < PHASE_CMDS; k++) draw_cmds.push_back(random_draw_cmd());
      drain();
    end

    repeat (40) @(posedge clk_i);
    mismatch_count += pending_results.size();
    if (mismatch_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ filelist.f @@
design/mfd_pkg.sv
design/mfd_ram.sv
design/mono_framebuffer_draw_unit.sv
dv/testbench.sv
